FILE: design/tbs_pkg.sv
// shared types, sizes and tree helper functions for the tree barrier
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TW          = 4;   // thread index width
    localparam int CW          = 5;   // thread count width
    localparam int ARITY       = 4;   // arrival tree fan-in

    typedef logic [TW-1:0]    t_tid;
    typedef logic [CW-1:0]    t_cnt;
    typedef logic [ARITY-1:0] t_kids;

    // command from the sequencer to the tree state
    typedef struct packed {
        logic reload;    // config write: reload the whole tree
        t_cnt cfg;       // raw count written
        logic mark;      // set arrived mark of tid
        logic free;      // clear arrived mark of tid
        t_tid tid;
        logic step;      // process node in the shared walk unit
        t_tid node;
    } t_tree_cmd;

    // status from the tree state back to the sequencer
    typedef struct packed {
        t_cnt count;
        logic tid_arrived;
        logic node_done;   // node arrived and all children ready
        t_tid parent;
    } t_tree_stat;

    // clamp the written count into 1..MAX_THREADS
    function automatic t_cnt eff_count(input t_cnt v);
        t_cnt r;
        r = v;
        if (v == '0) begin
            r = CW'(1);
        end else if (v > CW'(MAX_THREADS)) begin
            r = CW'(MAX_THREADS);
        end
        return r;
    endfunction

    // bit j set when child slot j of node n is a participating thread
    function automatic t_kids have_child(input t_tid n, input t_cnt cnt);
        t_kids      bits;
        logic [6:0] idx;
        bits = '0;
        for (int j = 0; j < ARITY; j++) begin
            idx = {1'b0, n, 2'b00} + 7'(j + 1);
            bits[j] = (idx < {2'b00, cnt});
        end
        return bits;
    endfunction

endpackage

FILE: design/tbs_tree.sv
// arrival tree state and the shared one-node walk step
`timescale 1ns / 1ps

module tbs_tree import tbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tree_cmd  i_cmd,
    output t_tree_stat o_stat
);

    t_cnt             r_count;
    t_kids            r_pending [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_arrived;

    t_tid nm1;
    t_cnt new_count;

    // parent and slot of the node under test
    assign nm1       = i_cmd.node - TW'(1);
    assign new_count = eff_count(i_cmd.cfg);

    assign o_stat.count       = r_count;
    assign o_stat.tid_arrived = r_arrived[i_cmd.tid];
    assign o_stat.node_done   = r_arrived[i_cmd.node] && (r_pending[i_cmd.node] == '0);
    assign o_stat.parent      = nm1 >> 2;

    // tree storage updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CW'(MAX_THREADS);
            r_arrived <= '0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_pending[i] <= have_child(TW'(i), CW'(MAX_THREADS));
            end
        end else if (i_cmd.reload) begin
            r_count   <= new_count;
            r_arrived <= '0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_pending[i] <= have_child(TW'(i), new_count);
            end
        end else begin
            if (i_cmd.mark) begin
                r_arrived[i_cmd.tid] <= 1'b1;
            end
            if (i_cmd.free) begin
                r_arrived[i_cmd.tid] <= 1'b0;
            end
            // node complete: reload its bits and report to the parent
            if (i_cmd.step && o_stat.node_done) begin
                r_pending[i_cmd.node] <= have_child(i_cmd.node, r_count);
                if (i_cmd.node != '0) begin
                    r_pending[o_stat.parent][nm1[1:0]] <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: design/tbs_seq.sv
// sequencer: accepts arrivals, drives the walk and the release burst
`timescale 1ns / 1ps

module tbs_seq import tbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_tid       i_arriving_thread,
    input  logic       i_cfg_we,
    input  t_cnt       i_cfg_data,
    input  t_tree_stat i_stat,
    output t_tree_cmd  o_cmd,
    output logic       busy,
    output logic       o_result_valid,
    output t_tid       o_released_thread,
    output logic       o_release_sense,
    output logic       o_repeat_error,
    output logic       o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_REL  = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_tid   r_node,  n_node;
    t_tid   r_idx,   n_idx;
    logic   r_sense, n_sense;
    logic   r_vld,   n_vld;
    t_tid   r_thr,   n_thr;
    logic   r_osense, n_osense;
    logic   r_err,   n_err;
    logic   r_last,  n_last;
    logic   rel_last;

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_vld;
    assign o_released_thread = r_thr;
    assign o_release_sense   = r_osense;
    assign o_repeat_error    = r_err;
    assign o_last            = r_last;

    assign rel_last = (({1'b0, r_idx} + CW'(1)) == i_stat.count);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_idx    = r_idx;
        n_sense  = r_sense;
        n_vld    = 1'b0;
        n_thr    = r_thr;
        n_osense = r_osense;
        n_err    = r_err;
        n_last   = r_last;
        o_cmd        = '0;
        o_cmd.reload = i_cfg_we;
        o_cmd.cfg    = i_cfg_data;
        o_cmd.node   = r_node;
        o_cmd.tid    = (r_state == S_REL) ? r_idx : i_arriving_thread;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_sense = 1'b1;
                end else if (start && ({1'b0, i_arriving_thread} < i_stat.count)) begin
                    if (i_stat.tid_arrived) begin
                        // repeated arrival: one error word
                        n_vld    = 1'b1;
                        n_thr    = i_arriving_thread;
                        n_osense = 1'b0;
                        n_err    = 1'b1;
                        n_last   = 1'b1;
                    end else begin
                        o_cmd.mark = 1'b1;
                        n_node     = i_arriving_thread;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (!i_stat.node_done) begin
                    n_state = S_IDLE;
                end else if (r_node == '0) begin
                    n_idx   = '0;
                    n_state = S_REL;
                end else begin
                    n_node = i_stat.parent;
                end
            end
            S_REL: begin
                // one released thread per cycle in index order
                o_cmd.free = 1'b1;
                n_vld    = 1'b1;
                n_thr    = r_idx;
                n_osense = r_sense;
                n_err    = 1'b0;
                n_last   = rel_last;
                if (rel_last) begin
                    n_sense = ~r_sense;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + TW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sense <= 1'b1;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sense <= n_sense;
            r_vld   <= n_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_idx    <= n_idx;
        r_thr    <= n_thr;
        r_osense <= n_osense;
        r_err    <= n_err;
        r_last   <= n_last;
    end

endmodule

FILE: design/tree_barrier_sync.sv
// top level of the tree barrier: sequencer plus arrival tree state
`timescale 1ns / 1ps

// Tree barrier for up to 16 threads with sense reversal.
// Arrival channel: drive i_arriving_thread with start high; the word is
// taken at a clock edge where start is high and busy is low.
// Result channel: o_result_valid marks each result word for one cycle;
// the receiver must take it, there is no back-pressure.
// Config: i_cfg_we with i_cfg_data writes the thread count (0 acts as 1,
// above 16 clamps to 16) and reloads the tree; write only while idle.
// Walk: an arrival walks the 4-ary arrival tree one node per cycle
// through a single shared node-step unit, testing at most 3 nodes for
// 16 threads, with busy high meanwhile.
// A completing arrival then releases count threads, one result word per
// cycle, each word formed in the release state and registered; busy drops
// while the last word is on the bus, so the next arrival can be taken at
// the edge that ends it. A repeated arrival gives one error word the
// cycle after it is taken, with busy staying low.
// An arrival that does not complete the root, or names a thread outside
// the count, gives no word. Reset sets count 16, clears all arrivals and
// sets the sense to one; the block is ready the cycle after reset.

module tree_barrier_sync import tbs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_tid   i_arriving_thread,
    input  logic   i_cfg_we,
    input  t_cnt   i_cfg_data,
    output logic   o_result_valid,
    output t_tid   o_released_thread,
    output logic   o_release_sense,
    output logic   o_repeat_error,
    output logic   o_last
);

    t_tree_cmd  cmd;
    t_tree_stat stat;

    // sequencer
    tbs_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .i_arriving_thread (i_arriving_thread),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_stat            (stat),
        .o_cmd             (cmd),
        .busy              (busy),
        .o_result_valid    (o_result_valid),
        .o_released_thread (o_released_thread),
        .o_release_sense   (o_release_sense),
        .o_repeat_error    (o_repeat_error),
        .o_last            (o_last)
    );

    // arrival tree state
    tbs_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

`ifndef SYNTHESIS
    // an error word is always the only word of its arrival
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_repeat_error |-> o_last)
        else $error("error word without last");

    // a release burst is still running until its last word
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_repeat_error && !o_last |-> busy)
        else $error("release burst ended early");

    // burst words are back to back and carry one sense
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_repeat_error && !o_last
        |=> o_result_valid && !o_repeat_error && $stable(o_release_sense))
        else $error("release burst broken");
`endif

endmodule

FILE: test/tbs_checker.sv
// barrier checker: tracks the tree state, predicts release words and compares them
`timescale 1ns / 1ps

module tbs_checker import tbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_tid i_arriving_thread,
    input  logic i_cfg_we,
    input  t_cnt i_cfg_data,
    input  logic i_result_valid,
    input  t_tid i_released_thread,
    input  logic i_release_sense,
    input  logic i_repeat_error,
    input  logic i_last,
    output int   o_fail_count,
    output int   o_words_pending,
    output int   o_arrivals,
    output int   o_releases,
    output int   o_repeats
);

    // one result word as the block should present it
    typedef struct packed {
        t_tid thread;
        logic sense;
        logic repeat_err;
        logic last;
    } t_release_word;

    t_release_word release_q[$];

    // mirror of the barrier state
    int    live_count;
    t_kids kids_waiting [MAX_THREADS];
    logic  arrived      [MAX_THREADS];
    logic  sense_q      [MAX_THREADS];
    logic  wake_q       [MAX_THREADS];

    task automatic report_mismatch(input string what);
        $display("[%0t] barrier check: %s", $time, what);
        o_fail_count++;
    endtask

    // slots of node that hold a participating thread
    function automatic t_kids kid_mask(input int node);
        t_kids bits;
        bits = '0;
        for (int j = 0; j < ARITY; j++) begin
            bits[j] = (ARITY * node + j + 1 < live_count);
        end
        return bits;
    endfunction

    // new count: clamp and reload every node
    task automatic reload_state(input t_cnt raw);
        if (raw == 0) begin
            live_count = 1;
        end else if (int'(raw) > MAX_THREADS) begin
            live_count = MAX_THREADS;
        end else begin
            live_count = int'(raw);
        end
        for (int n = 0; n < MAX_THREADS; n++) begin
            kids_waiting[n] = kid_mask(n);
            arrived[n]      = 1'b0;
            sense_q[n]      = 1'b1;
            wake_q[n]       = 1'b0;
        end
    endtask

    // one arrival: walk up the arrival tree, release everyone if the root completes
    task automatic predict_arrival(input t_tid tid);
        int            node;
        int            up;
        logic          root_done;
        logic          climbing;
        logic          s;
        t_release_word w;
        if (int'(tid) >= live_count) begin
            return;
        end
        o_arrivals++;
        if (arrived[tid]) begin
            w = '{thread: tid, sense: 1'b0, repeat_err: 1'b1, last: 1'b1};
            release_q.push_back(w);
            return;
        end
        arrived[tid] = 1'b1;
        node = int'(tid);
        root_done = 1'b0;
        climbing = 1'b1;
        while (climbing && arrived[node] && kids_waiting[node] == '0) begin
            kids_waiting[node] = kid_mask(node);
            if (node == 0) begin
                root_done = 1'b1;
                climbing = 1'b0;
            end else begin
                up = (node - 1) / ARITY;
                kids_waiting[up][(node - 1) % ARITY] = 1'b0;
                node = up;
            end
        end
        if (!root_done) begin
            return;
        end
        // release burst in index order
        for (int n = 0; n < live_count; n++) begin
            s = sense_q[n];
            if (2 * n + 1 < live_count) begin
                wake_q[2 * n + 1] = s;
            end
            if (2 * n + 2 < live_count) begin
                wake_q[2 * n + 2] = s;
            end
            sense_q[n] = ~s;
            arrived[n] = 1'b0;
            w = '{thread: t_tid'(n), sense: s, repeat_err: 1'b0,
                  last: (n + 1 == live_count)};
            release_q.push_back(w);
        end
    endtask

    // per edge: compare the word on the bus, then take config and arrivals
    always @(posedge i_clk) begin : watch
        t_release_word want;
        t_release_word got;
        if (!i_rst_n) begin
            reload_state(t_cnt'(MAX_THREADS));
            release_q.delete();
        end else begin
            if (i_result_valid) begin
                got = '{thread: i_released_thread, sense: i_release_sense,
                        repeat_err: i_repeat_error, last: i_last};
                if (got.repeat_err) begin
                    o_repeats++;
                end else begin
                    o_releases++;
                end
                if (release_q.size() == 0) begin
                    report_mismatch($sformatf({"unexpected word thread %0d sense %0b ",
                                               "err %0b last %0b"},
                                              got.thread, got.sense, got.repeat_err, got.last));
                end else begin
                    want = release_q.pop_front();
                    if (got != want) begin
                        report_mismatch($sformatf({"word thread/sense/err/last got ",
                                                   "%0d/%0b/%0b/%0b want %0d/%0b/%0b/%0b"},
                                                  got.thread, got.sense, got.repeat_err, got.last,
                                                  want.thread, want.sense, want.repeat_err,
                                                  want.last));
                    end
                end
            end
            if (i_cfg_we) begin
                reload_state(i_cfg_data);
            end
            if (i_start && !i_busy) begin
                predict_arrival(i_arriving_thread);
            end
        end
        o_words_pending <= release_q.size();
    end

endmodule

FILE: test/tb_tree_barrier_sync.sv
// testbench top for the tree barrier: reset, arrival stimulus, config writes, verdict
`timescale 1ns / 1ps

module tb_tree_barrier_sync;
    import tbs_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 95;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_tid i_arriving_thread;
    logic i_cfg_we;
    t_cnt i_cfg_data;
    logic o_result_valid;
    t_tid o_released_thread;
    logic o_release_sense;
    logic o_repeat_error;
    logic o_last;

    int fail_count;
    int words_pending;
    int arrivals;
    int releases;
    int repeats;

    int idle_pct;
    int live_count;
    int items_sent;
    int counts_tried;

    tree_barrier_sync dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_arriving_thread (i_arriving_thread),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_released_thread (o_released_thread),
        .o_release_sense   (o_release_sense),
        .o_repeat_error    (o_repeat_error),
        .o_last            (o_last)
    );

    tbs_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_arriving_thread (i_arriving_thread),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_result_valid    (o_result_valid),
        .i_released_thread (o_released_thread),
        .i_release_sense   (o_release_sense),
        .i_repeat_error    (o_repeat_error),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_words_pending   (words_pending),
        .o_arrivals        (arrivals),
        .o_releases        (releases),
        .o_repeats         (repeats)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("watchdog expired with %0d words outstanding", words_pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one arrival word, held until taken, then a random gap
    task automatic drive_arrival(input t_tid tid);
        start <= 1'b1;
        i_arriving_thread <= tid;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (int'(tid) < live_count) begin
            items_sent++;
        end
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
    endtask

    // stop sending, wait for every expected word, then let any walk finish
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_thread_count(input t_cnt raw);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (raw == 0) begin
            live_count = 1;
        end else if (int'(raw) > MAX_THREADS) begin
            live_count = MAX_THREADS;
        end else begin
            live_count = int'(raw);
        end
        counts_tried++;
    endtask

    // shuffled arrival of every thread, with repeats, outsiders and early cut-offs mixed in
    task automatic run_episode();
        t_tid order[$];
        t_tid tmp;
        int   j;
        int   cut;
        order.delete();
        for (int k = 0; k < live_count; k++) begin
            order.push_back(t_tid'(k));
        end
        for (int k = live_count - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        cut = live_count;
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(live_count - 1);
        end
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(9) == 0) begin
                if (k > 0 && ($urandom_range(1) == 1 || live_count == MAX_THREADS)) begin
                    drive_arrival(order[$urandom_range(k - 1)]);
                end else if (live_count < MAX_THREADS) begin
                    drive_arrival(t_tid'($urandom_range(MAX_THREADS - 1, live_count)));
                end
            end
            drive_arrival(order[k]);
        end
    endtask

    initial begin : stimulus
        int   phase_pct [4];
        t_cnt raw;
        int   pick;
        phase_pct = '{0, 86, 34, 0};
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_arriving_thread <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        idle_pct     = 0;
        live_count   = MAX_THREADS;
        items_sent   = 0;
        counts_tried = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full barrier at reset count, root first, with a repeat of the root
        drive_arrival(t_tid'(0));
        drive_arrival(t_tid'(0));
        for (int t = 1; t < MAX_THREADS; t++) begin
            drive_arrival(t_tid'(t));
        end

        // zero count acts as one thread, outsider ignored
        write_thread_count(t_cnt'(0));
        drive_arrival(t_tid'(0));
        drive_arrival(t_tid'(15));
        drive_arrival(t_tid'(0));

        // saturating count, a leaf left waiting, then a reload mid-episode
        write_thread_count(t_cnt'(31));
        drive_arrival(t_tid'(15));
        write_thread_count(t_cnt'(3));
        drive_arrival(t_tid'(2));
        drive_arrival(t_tid'(1));
        drive_arrival(t_tid'(0));

        // random episodes over several counts, one idle pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_pct[ph];
            while (items_sent < (ph + 1) * PHASE_ITEMS) begin
                pick = $urandom_range(9);
                if (pick == 0) begin
                    raw = '0;
                end else if (pick == 1) begin
                    raw = t_cnt'($urandom_range(31, MAX_THREADS + 1));
                end else if (pick < 4) begin
                    raw = t_cnt'($urandom_range(4, 1));
                end else begin
                    raw = t_cnt'($urandom_range(MAX_THREADS, 1));
                end
                write_thread_count(raw);
                repeat ($urandom_range(3, 1)) run_episode();
            end
        end

        settle();
        $display("ran %0d arrivals over %0d thread-count settings", arrivals, counts_tried);
        $display("checked %0d release words and %0d repeat errors", releases, repeats);
        if (fail_count == 0 && words_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
